FILE: src/mhfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mhfd_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int LIMIT_W    = 16;
  localparam int POS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int MAGIC_BYTES  = 4;
  localparam int HEADER_BYTES = 8;
  localparam int ID_BYTES     = 8;

  localparam logic [LIMIT_W-1:0] MAX_LEN_RESET = 16'd8192;

  localparam logic [CFG_IDX_W-1:0] CFG_CONN_MAGIC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_MAGIC   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

  typedef enum logic [1:0] {
    KIND_PEER  = 2'd0,
    KIND_START = 2'd1,
    KIND_BODY  = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic               last;
    logic [WORD_W-1:0]  peer_id;
    logic [WORD_W-1:0]  peer_mailbox;
    logic [WORD_W-1:0]  msg_len;
  } result_t;

  // big-endian byte of a magic word
  function automatic logic [BYTE_W-1:0] magic_byte(input logic [WORD_W-1:0] word,
                                                   input logic [1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      2'd0:    b = word[31:24];
      2'd1:    b = word[23:16];
      2'd2:    b = word[15:8];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [WORD_W-1:0] put_byte(input logic [WORD_W-1:0] word,
                                                 input logic [1:0] pos,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] w;
    w = word;
    case (pos)
      2'd0:    w[31:24] = b;
      2'd1:    w[23:16] = b;
      2'd2:    w[15:8]  = b;
      default: w[7:0]   = b;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: src/mhfd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mhfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [mhfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: src/mhfd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mhfd_out_if;
  logic                        valid;
  logic                        ready;
  mhfd_pkg::kind_t             kind;
  logic [mhfd_pkg::BYTE_W-1:0] data_byte;
  logic                        last;
  logic [mhfd_pkg::WORD_W-1:0] peer_id;
  logic [mhfd_pkg::WORD_W-1:0] peer_mailbox;
  logic [mhfd_pkg::WORD_W-1:0] msg_len;

  modport source (output valid, output kind, output data_byte, output last,
                  output peer_id, output peer_mailbox, output msg_len, input ready);
  modport sink   (input valid, input kind, input data_byte, input last,
                  input peer_id, input peer_mailbox, input msg_len, output ready);
endinterface

`default_nettype wire

FILE: src/mhfd_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module mhfd_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mhfd_pkg::result_t push_data,
  output logic                   push_ready,
  mhfd_out_if.source             out_ch
);

  mhfd_pkg::result_t out_r;
  mhfd_pkg::result_t skid_r;
  logic              out_valid_r;
  logic              skid_valid_r;
  logic              out_fire;

  assign out_fire   = out_valid_r && out_ch.ready;
  assign push_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_fire) begin
        out_r       <= push_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.data_byte    = out_r.data_byte;
  assign out_ch.last         = out_r.last;
  assign out_ch.peer_id      = out_r.peer_id;
  assign out_ch.peer_mailbox = out_r.peer_mailbox;
  assign out_ch.msg_len      = out_r.msg_len;

endmodule

`default_nettype wire

FILE: src/magic_header_frame_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// A result is registered into the output stage when the item that causes it is accepted.
// Throughput: one item per cycle while in_ch.ready is high; the frame state machine does constant work per byte.
// A two-entry output stage (result register plus skid register) keeps in_ch ready
// while one result waits; ready drops only when both entries are full.
// Reset (synchronous, rst_n low): hunt state, output stage empty, magics 0, limit 8192.
module magic_header_frame_deframer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  mhfd_in_if.sink                                  in_ch,
  mhfd_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [mhfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mhfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_ID   = 2'd1,
    PH_LEN  = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  phase_t                            phase_r, phase_nxt;
  logic [mhfd_pkg::POS_W-1:0]        position_r, position_nxt;
  logic [mhfd_pkg::WORD_W-1:0]       header_r, header_nxt;
  logic [2*mhfd_pkg::WORD_W-1:0]     id_r, id_nxt;
  logic [mhfd_pkg::WORD_W-1:0]       flen_r, flen_nxt;

  logic [mhfd_pkg::WORD_W-1:0]       conn_magic_r;
  logic [mhfd_pkg::WORD_W-1:0]       msg_magic_r;
  logic [mhfd_pkg::LIMIT_W-1:0]      max_len_r;

  logic                              accept;
  logic                              push_ready;
  logic                              res_valid;
  mhfd_pkg::result_t                 res;

  logic [1:0]                        hpos;
  logic [mhfd_pkg::BYTE_W-1:0]       b;
  logic [mhfd_pkg::POS_W:0]          body_next;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign b           = in_ch.rx_byte;
  assign hpos        = position_r[1:0];
  assign body_next   = {1'b0, position_r} + 17'd1;

  always_comb begin
    phase_nxt    = phase_r;
    position_nxt = position_r;
    header_nxt   = header_r;
    id_nxt       = id_r;
    flen_nxt     = flen_r;
    res_valid    = 1'b0;
    res          = '0;
    case (phase_r)
      PH_HUNT: begin
        header_nxt = mhfd_pkg::put_byte(header_r, hpos, b);
        if (b == mhfd_pkg::magic_byte(conn_magic_r, hpos) ||
            b == mhfd_pkg::magic_byte(msg_magic_r, hpos)) begin
          if (hpos == 2'(mhfd_pkg::MAGIC_BYTES - 1)) begin
            position_nxt = '0;
            if (header_nxt == conn_magic_r) begin
              phase_nxt = PH_ID;
            end else if (header_nxt == msg_magic_r) begin
              phase_nxt = PH_LEN;
            end
          end else begin
            position_nxt = {{(mhfd_pkg::POS_W-2){1'b0}}, hpos + 2'd1};
          end
        end else begin
          position_nxt = '0;
        end
      end
      PH_ID: begin
        id_nxt = {id_r[2*mhfd_pkg::WORD_W-mhfd_pkg::BYTE_W-1:0], b};
        if (position_r[2:0] == 3'(mhfd_pkg::ID_BYTES - 1)) begin
          position_nxt     = '0;
          phase_nxt        = PH_HUNT;
          res_valid        = 1'b1;
          res.kind         = mhfd_pkg::KIND_PEER;
          res.peer_id      = id_nxt[2*mhfd_pkg::WORD_W-1:mhfd_pkg::WORD_W];
          res.peer_mailbox = id_nxt[mhfd_pkg::WORD_W-1:0];
        end else begin
          position_nxt = position_r + 16'd1;
        end
      end
      PH_LEN: begin
        flen_nxt = {flen_r[mhfd_pkg::WORD_W-mhfd_pkg::BYTE_W-1:0], b};
        if (hpos == 2'(mhfd_pkg::MAGIC_BYTES - 1)) begin
          res_valid   = 1'b1;
          res.msg_len = flen_nxt;
          if (flen_nxt < 32'(mhfd_pkg::HEADER_BYTES) ||
              flen_nxt > {16'd0, max_len_r}) begin
            position_nxt = '0;
            phase_nxt    = PH_HUNT;
            res.kind     = mhfd_pkg::KIND_BAD;
          end else if (flen_nxt == 32'(mhfd_pkg::HEADER_BYTES)) begin
            position_nxt = '0;
            phase_nxt    = PH_HUNT;
            res.kind     = mhfd_pkg::KIND_START;
            res.last     = 1'b1;
          end else begin
            position_nxt = 16'(mhfd_pkg::HEADER_BYTES);
            phase_nxt    = PH_BODY;
            res.kind     = mhfd_pkg::KIND_START;
          end
        end else begin
          position_nxt = position_r + 16'd1;
        end
      end
      default: begin
        res_valid     = 1'b1;
        res.kind      = mhfd_pkg::KIND_BODY;
        res.data_byte = b;
        if (body_next >= {1'b0, flen_r[mhfd_pkg::POS_W-1:0]}) begin
          position_nxt = '0;
          phase_nxt    = PH_HUNT;
          res.last     = 1'b1;
        end else begin
          position_nxt = body_next[mhfd_pkg::POS_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      position_r   <= '0;
      conn_magic_r <= '0;
      msg_magic_r  <= '0;
      max_len_r    <= mhfd_pkg::MAX_LEN_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mhfd_pkg::CFG_CONN_MAGIC: conn_magic_r <= cfg_wdata;
          mhfd_pkg::CFG_MSG_MAGIC:  msg_magic_r  <= cfg_wdata;
          mhfd_pkg::CFG_MAX_LEN:    max_len_r    <= cfg_wdata[mhfd_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_r    <= phase_nxt;
        position_r <= position_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      header_r <= header_nxt;
      id_r     <= id_nxt;
      flen_r   <= flen_nxt;
    end
  end

  mhfd_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && res_valid),
    .push_data  (res),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
